[rtl/core/svo_pkg.sv]
// Package for the sparse voxel octree core: state codes, command codes, control and status structs, constants.
// No dependencies.
`default_nettype none
package svo_pkg;
    localparam int ADDR_SLOT_BITS = 3;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [16:0] {
        ST_INIT    = 17'b00000000000000001,
        ST_IDLE    = 17'b00000000000000010,
        ST_DRD     = 17'b00000000000000100,
        ST_DWT     = 17'b00000000000001000,
        ST_CNTRD   = 17'b00000000000010000,
        ST_CNTWT   = 17'b00000000000100000,
        ST_TAKERD  = 17'b00000000001000000,
        ST_TAKEWT  = 17'b00000000010000000,
        ST_ZERO    = 17'b00000000100000000,
        ST_LINK    = 17'b00000001000000000,
        ST_LEAFWR  = 17'b00000010000000000,
        ST_CHKRD   = 17'b00000100000000000,
        ST_CHKWT   = 17'b00001000000000000,
        ST_FREE    = 17'b00010000000000000,
        ST_UNLINK  = 17'b00100000000000000,
        ST_RDLEAF  = 17'b01000000000000000,
        ST_DONE    = 17'b10000000000000000
    } state_t;

    typedef struct packed {
        logic init_step;   // write one store entry of the clearing pass
        logic load;        // capture input word
        logic rd_walk;     // read slot(cur, digit(lvl))
        logic step_down;   // cur <= data, record path, lvl--
        logic cnt_start;   // f <= free_head, k <= 0
        logic rd_f;        // read slot(f,0)
        logic cnt_step;    // f <= data, k++
        logic rd_head;     // read slot(free_head,0)
        logic take;        // new <= free_head, free_head <= data, zk <= 0
        logic zero_wr;     // write slot(new, zk) = 0, zk++
        logic link_wr;     // write slot(cur,digit(lvl)) = new, cur<=new, lvl--
        logic leaf_wr;     // write leaf value (val or 0)
        logic chk_start;   // zk <= 0
        logic rd_chk;      // read slot(cur, zk)
        logic chk_step;    // zk++
        logic give_wr;     // slot(cur,0) = free_head, free_head <= cur, lvl++
        logic unlink_wr;   // cur <= path[lvl], write slot(cur,digit(lvl))=0
        logic rd_leaf;     // capture read value
        logic set_full;
    } ctl_t;

    typedef struct packed {
        logic       init_last;
        cmd_t       cmd;
        logic       data_zero;
        logic       lvl_ge1;
        logic       cnt_done;   // k >= lvl
        logic       f_zero;
        logic       zk_last;
        logic       cur_zero;
        logic       lvl_top;    // lvl == DEPTH after increment
    } sts_t;
endpackage
`default_nettype wire

[rtl/core/svo_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module svo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

[rtl/core/svo_ctrl.sv]
// Controller state machine for the octree core.
// Depends on svo_pkg.
`default_nettype none
module svo_ctrl import svo_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    input  wire sts_t sts,
    output ctl_t      ctl
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_DONE);

    always_comb begin
        state_next = state_reg;
        ctl = '0;
        case (state_reg)
            ST_INIT: begin
                ctl.init_step = 1'b1;
                if (sts.init_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    ctl.load = 1'b1;
                    state_next = ST_DRD;
                end
            end
            ST_DRD: begin
                if (sts.cmd == CMD_NONE) begin
                    state_next = ST_DONE;
                end else if (sts.lvl_ge1) begin
                    ctl.rd_walk = 1'b1;
                    state_next = ST_DWT;
                end else if (sts.cmd == CMD_WRITE) begin
                    ctl.cnt_start = 1'b1;
                    state_next = ST_CNTRD;
                end else if (sts.cmd == CMD_CLEAR) begin
                    ctl.leaf_wr = 1'b1;
                    ctl.chk_start = 1'b1;
                    state_next = ST_CHKRD;
                end else begin
                    ctl.rd_walk = 1'b1;
                    state_next = ST_RDLEAF;
                end
            end
            ST_DWT: begin
                if (sts.data_zero) begin
                    if (sts.cmd == CMD_WRITE) begin
                        ctl.cnt_start = 1'b1;
                        state_next = ST_CNTRD;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else begin
                    ctl.step_down = 1'b1;
                    state_next = ST_DRD;
                end
            end
            ST_CNTRD: begin
                if (sts.cnt_done) begin
                    state_next = sts.lvl_ge1 ? ST_TAKERD : ST_LEAFWR;
                end else if (sts.f_zero) begin
                    ctl.set_full = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    ctl.rd_f = 1'b1;
                    state_next = ST_CNTWT;
                end
            end
            ST_CNTWT: begin
                ctl.cnt_step = 1'b1;
                state_next = ST_CNTRD;
            end
            ST_TAKERD: begin
                ctl.rd_head = 1'b1;
                state_next = ST_TAKEWT;
            end
            ST_TAKEWT: begin
                ctl.take = 1'b1;
                state_next = ST_ZERO;
            end
            ST_ZERO: begin
                ctl.zero_wr = 1'b1;
                if (sts.zk_last) state_next = ST_LINK;
            end
            ST_LINK: begin
                ctl.link_wr = 1'b1;
                state_next = ST_CNTRD;
            end
            ST_LEAFWR: begin
                ctl.leaf_wr = 1'b1;
                state_next = ST_DONE;
            end
            ST_CHKRD: begin
                if (sts.cur_zero) begin
                    state_next = ST_DONE;
                end else begin
                    ctl.rd_chk = 1'b1;
                    state_next = ST_CHKWT;
                end
            end
            ST_CHKWT: begin
                ctl.chk_step = 1'b1;
                if (!sts.data_zero) state_next = ST_DONE;
                else if (sts.zk_last) state_next = ST_FREE;
                else state_next = ST_CHKRD;
            end
            ST_FREE: begin
                ctl.give_wr = 1'b1;
                state_next = ST_UNLINK;
            end
            ST_UNLINK: begin
                if (sts.lvl_top) begin
                    state_next = ST_DONE;
                end else begin
                    ctl.unlink_wr = 1'b1;
                    ctl.chk_start = 1'b1;
                    state_next = ST_CHKRD;
                end
            end
            ST_RDLEAF: begin
                ctl.rd_leaf = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_INIT;
        endcase
    end
endmodule
`default_nettype wire

[rtl/core/svo_dp.sv]
// Datapath for the octree core: node store, walk registers, free list.
// Depends on svo_pkg and svo_ram.
`default_nettype none
module svo_dp import svo_pkg::*; #(
    parameter int DEPTH      = 10,
    parameter int NODE_COUNT = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [1:0]  s_command,
    input  wire logic [9:0]  s_coord_x,
    input  wire logic [9:0]  s_coord_y,
    input  wire logic [9:0]  s_coord_z,
    input  wire logic [31:0] s_voxel_value,
    output logic      [31:0] m_read_value,
    output logic             m_status,
    input  wire ctl_t        ctl,
    output sts_t             sts
);
    localparam int NW = $clog2(NODE_COUNT);
    localparam int AW = NW + ADDR_SLOT_BITS;
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (DEPTH > 10) ? DEPTH : 10;

    logic [1:0]          cmd_reg;
    logic [DEPTH-1:0]    x_reg, y_reg, z_reg;
    logic [31:0]         val_reg;
    logic [NW-1:0]       cur_reg, f_reg, head_reg, new_reg;
    logic [AW-1:0]       init_reg;
    logic [LW-1:0]       lvl_reg, k_reg;
    logic [2:0]          zk_reg;
    logic [31:0]         rv_reg;
    logic                st_reg;
    logic [NW-1:0]       path_reg [DEPTH];

    logic                we;
    logic [AW-1:0]       addr;
    logic [31:0]         wdata, rdata;
    logic [2:0]          dig;
    logic [LW-1:0]       lvl_dig;
    logic [NW-1:0]       rnode;
    logic [NW-1:0]       init_node;
    logic [CW-1:0]       cx, cy, cz;

    assign cx = CW'(s_coord_x);
    assign cy = CW'(s_coord_y);
    assign cz = CW'(s_coord_z);

    function automatic logic [NW-1:0] guard(input logic [31:0] n);
        return (n < 32'(NODE_COUNT)) ? n[NW-1:0] : '0;
    endfunction

    assign rnode     = guard(rdata);
    assign init_node = init_reg[AW-1:ADDR_SLOT_BITS];
    assign lvl_dig   = (ctl.leaf_wr || ctl.rd_leaf) ? '0 : lvl_reg;
    assign dig = {z_reg[lvl_dig], y_reg[lvl_dig], x_reg[lvl_dig]};

    always_comb begin
        we = 1'b0;
        addr = {cur_reg, dig};
        wdata = '0;
        if (ctl.init_step) begin
            we = 1'b1;
            addr = init_reg;
            wdata = (init_reg[ADDR_SLOT_BITS-1:0] == '0 && init_node != '0
                     && init_node != NW'(NODE_COUNT - 1))
                    ? 32'(init_node) + 32'd1 : '0;
        end else if (ctl.rd_f) begin
            addr = {f_reg, 3'd0};
        end else if (ctl.rd_head) begin
            addr = {head_reg, 3'd0};
        end else if (ctl.zero_wr) begin
            we = 1'b1;
            addr = {new_reg, zk_reg};
        end else if (ctl.link_wr) begin
            we = 1'b1;
            wdata = 32'(new_reg);
        end else if (ctl.leaf_wr) begin
            we = 1'b1;
            wdata = (cmd_reg == CMD_WRITE) ? val_reg : '0;
        end else if (ctl.rd_chk) begin
            addr = {cur_reg, zk_reg};
        end else if (ctl.give_wr) begin
            we = 1'b1;
            addr = {cur_reg, 3'd0};
            wdata = 32'(head_reg);
        end else if (ctl.unlink_wr) begin
            we = 1'b1;
            addr = {path_reg[lvl_reg], dig};
        end
    end

    svo_ram #(.WIDTH(32), .DEPTH(NODE_COUNT * 8)) u_store (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg <= '0;
            head_reg <= NW'(1);
        end else begin
            if (ctl.init_step) init_reg <= init_reg + AW'(1);
            if (ctl.take) head_reg <= rnode;
            if (ctl.give_wr) head_reg <= cur_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg <= s_command;
            x_reg   <= cx[DEPTH-1:0];
            y_reg   <= cy[DEPTH-1:0];
            z_reg   <= cz[DEPTH-1:0];
            val_reg <= s_voxel_value;
            cur_reg <= '0;
            lvl_reg <= LW'(DEPTH - 1);
            rv_reg  <= '0;
            st_reg  <= 1'b0;
        end
        if (ctl.step_down) begin
            path_reg[lvl_reg] <= cur_reg;
            cur_reg <= rnode;
            lvl_reg <= lvl_reg - LW'(1);
        end
        if (ctl.cnt_start) begin
            f_reg <= head_reg;
            k_reg <= '0;
        end
        if (ctl.cnt_step) begin
            f_reg <= rnode;
            k_reg <= k_reg + LW'(1);
        end
        if (ctl.take) begin
            new_reg <= head_reg;
            zk_reg  <= '0;
        end
        if (ctl.zero_wr) zk_reg <= zk_reg + 3'd1;
        if (ctl.link_wr) begin
            cur_reg <= new_reg;
            lvl_reg <= lvl_reg - LW'(1);
        end
        if (ctl.chk_start) zk_reg <= '0;
        if (ctl.chk_step) zk_reg <= zk_reg + 3'd1;
        if (ctl.give_wr) lvl_reg <= lvl_reg + LW'(1);
        if (ctl.unlink_wr) cur_reg <= path_reg[lvl_reg];
        if (ctl.rd_leaf) rv_reg <= rdata;
        if (ctl.set_full) st_reg <= 1'b1;
    end

    assign m_read_value = rv_reg;
    assign m_status     = st_reg;

    // count stays at the checked need, so it passes again after each link
    assign sts.init_last = (init_reg == AW'(NODE_COUNT * 8 - 1));
    assign sts.cmd       = cmd_t'(cmd_reg);
    assign sts.data_zero = (rdata == '0);
    assign sts.lvl_ge1   = (lvl_reg != '0);
    assign sts.cnt_done  = (k_reg >= lvl_reg);
    assign sts.f_zero    = (f_reg == '0);
    assign sts.zk_last   = (zk_reg == 3'd7);
    assign sts.cur_zero  = (cur_reg == '0);
    assign sts.lvl_top   = (lvl_reg == LW'(DEPTH));
endmodule
`default_nettype wire

[rtl/core/sparse_voxel_octree_table_core.sv]
// Sparse voxel octree core: top level joining controller and datapath.
// Depends on svo_pkg, svo_ctrl, svo_dp, svo_ram.
// One word in, one word out. After reset a clearing pass writes every slot of the node
// store and links the free chain; no word is taken until it ends. Each word then walks
// the single-port node store one access per level. A write that must create levels
// below the root runs a free-list count, then take, eight-slot zeroing and link per new
// node; a clear that empties nodes on the path frees them on the way back up after an
// eight-slot check per node. A result waiting for m_ready holds off the next word.
`default_nettype none
module sparse_voxel_octree_table_core import svo_pkg::*; #(
    parameter int DEPTH      = 10,
    parameter int NODE_COUNT = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [9:0]  s_coord_x,
    input  wire logic [9:0]  s_coord_y,
    input  wire logic [9:0]  s_coord_z,
    input  wire logic [31:0] s_voxel_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [31:0] m_read_value,
    output logic             m_status
);
    ctl_t ctl;
    sts_t sts;

    svo_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .ctl(ctl)
    );

    svo_dp #(.DEPTH(DEPTH), .NODE_COUNT(NODE_COUNT)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_command(s_command),
        .s_coord_x(s_coord_x), .s_coord_y(s_coord_y), .s_coord_z(s_coord_z),
        .s_voxel_value(s_voxel_value), .m_read_value(m_read_value),
        .m_status(m_status), .ctl(ctl), .sts(sts)
    );
endmodule
`default_nettype wire

[rtl/core/svo_checker.sv]
// Port-level checker for the octree core, bound to the top level.
// Depends on sparse_voxel_octree_table_core.
`default_nettype none
module svo_props (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_read_value,
    input wire logic        m_status
);
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready while result pending");
    a_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("took two words");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_value) && $stable(m_status))
        else $error("result dropped");
    a_rv: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_read_value != 32'd0 |-> !m_status)
        else $error("read value with error");
endmodule

bind sparse_voxel_octree_table_core svo_props u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready),
    .m_read_value(m_read_value), .m_status(m_status)
);
`default_nettype wire
